>>> rtl/core/fbpa_pkg.sv
// ----------------------------------------------------------------------------
// fbpa_pkg
// Shared types and constants of the fixed block pool allocator.
// ----------------------------------------------------------------------------
package fbpa_pkg;

  localparam int CFG_W   = 32;  // widest configuration register
  localparam int BYTES_W = 16;  // block size register
  localparam int COUNT_W = 9;   // block count register, used count

  localparam logic [COUNT_W-1:0] USED_MAX = '1;

  typedef enum logic [1:0] {
    REG_POOL_BASE   = 2'd0,
    REG_BLOCK_BYTES = 2'd1,
    REG_BLOCK_COUNT = 2'd2,
    REG_UNUSED      = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    OP_INIT  = 2'd0,
    OP_ALLOC = 2'd1,
    OP_FREE  = 2'd2,
    OP_QUERY = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BAD_LEN = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_REJECT  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INIT,
    S_ALLOC_RD,
    S_ALLOC_ADD,
    S_DIV,
    S_EMIT
  } state_t;

  // divider status towards the controller
  typedef struct packed {
    logic done;
    logic rem_zero;
  } div_stat_t;

endpackage

>>> rtl/core/fixed_block_pool_allocator.sv
// ----------------------------------------------------------------------------
// fixed_block_pool_allocator
// Free-list allocator for a pool of equal blocks; links live in one RAM.
// Init writes one link per cycle through the single RAM write port; the free
// path runs through the bit-serial divider.
// One request at a time: a new request is not taken until the previous one has
// left the emit step. A new request is taken while a result waits in the
// output register.
// Synchronous reset empties the free list, zeroes the used count and loads the
// register defaults; the link RAM is not cleared and only holds meaning after
// an init.
// ----------------------------------------------------------------------------
module fixed_block_pool_allocator import fbpa_pkg::*; #(
  parameter int POOL_DEPTH = 256,
  parameter int ADDR_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  // configuration
  input  logic                  cfg_write,
  input  logic [1:0]            cfg_index,
  input  logic [CFG_W-1:0]      cfg_data,
  // request channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            operation,
  input  logic [ADDR_WIDTH-1:0] address,
  // result channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [1:0]            status,
  output logic [ADDR_WIDTH-1:0] block_address,
  output logic [COUNT_W-1:0]    used_count
);

  // index into the link RAM, and a link that can also hold the end marker
  localparam int IDX_W  = $clog2(POOL_DEPTH);
  localparam int LINK_W = $clog2(POOL_DEPTH + 1);
  localparam int CMP_W  = (LINK_W > COUNT_W) ? LINK_W : COUNT_W;
  localparam int QW     = (ADDR_WIDTH > CMP_W) ? ADDR_WIDTH : CMP_W;
  localparam int PROD_W = IDX_W + BYTES_W;
  localparam logic [LINK_W-1:0] LINK_END = LINK_W'(POOL_DEPTH);

  state_t state, state_next;

  // configuration registers
  logic [CFG_W-1:0]   pool_base;
  logic [BYTES_W-1:0] block_bytes;
  logic [COUNT_W-1:0] block_count;

  // allocator state outside the RAM
  logic [LINK_W-1:0]  free_head;
  logic [COUNT_W-1:0] blocks_used;

  // per-request working registers
  logic [IDX_W-1:0]      init_cnt;
  logic [IDX_W-1:0]      init_last;
  logic [PROD_W-1:0]     prod;
  status_t               res_status;
  logic [ADDR_WIDTH-1:0] res_addr;

  // link RAM ports
  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  logic [LINK_W-1:0] ram_wdata;
  logic [LINK_W-1:0] ram_rdata;

  // divider
  logic                  div_start;
  div_stat_t             div_stat;
  logic [ADDR_WIDTH-1:0] quot;

  // decode
  logic                  in_accept;
  logic                  out_free;
  op_t                   op_in;
  logic [ADDR_WIDTH-1:0] base_m;
  logic [ADDR_WIDTH-1:0] offset;
  logic                  count_bad;
  logic                  head_empty;
  logic                  free_pre_bad;
  logic                  free_ok;
  logic [LINK_W-1:0]     link_in;

  assign in_stall  = (state != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign op_in     = op_t'(operation);

  assign base_m       = ADDR_WIDTH'(pool_base);
  assign offset       = address - base_m;
  assign count_bad    = (block_count == '0) || (CMP_W'(block_count) > CMP_W'(POOL_DEPTH));
  assign head_empty   = (free_head >= LINK_END);
  assign free_pre_bad = (address < base_m) || (block_bytes == '0);
  // exact multiple, and the index lies inside both the pool and the RAM
  assign free_ok      = div_stat.rem_zero
                        && (QW'(quot) < QW'(block_count))
                        && (QW'(quot) < QW'(POOL_DEPTH));
  // a link past the end marker is clamped to it
  assign link_in      = (ram_rdata > LINK_END) ? LINK_END : ram_rdata;

  fbpa_ram #(
    .WIDTH (LINK_W),
    .DEPTH (POOL_DEPTH)
  ) u_link_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (free_head[IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  fbpa_div #(
    .DW (ADDR_WIDTH)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (offset),
    .divisor  (block_bytes),
    .stat     (div_stat),
    .quotient (quot)
  );

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state, RAM write and divider start
  always_comb begin
    state_next = state;
    ram_we     = 1'b0;
    ram_waddr  = init_cnt;
    ram_wdata  = (init_cnt == init_last) ? LINK_END : LINK_W'(init_cnt) + 1'b1;
    div_start  = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_accept) begin
          unique case (op_in)
            OP_INIT:  state_next = count_bad ? S_EMIT : S_INIT;
            OP_ALLOC: state_next = head_empty ? S_EMIT : S_ALLOC_RD;
            OP_FREE: begin
              if (free_pre_bad) begin
                state_next = S_EMIT;
              end else begin
                div_start  = 1'b1;
                state_next = S_DIV;
              end
            end
            OP_QUERY: state_next = S_EMIT;
            default:  state_next = S_EMIT;
          endcase
        end
      end
      S_INIT: begin
        // chain i -> i + 1, last entry ends the list
        ram_we = 1'b1;
        if (init_cnt == init_last) begin
          state_next = S_EMIT;
        end
      end
      S_ALLOC_RD:  state_next = S_ALLOC_ADD;
      S_ALLOC_ADD: state_next = S_EMIT;
      S_DIV: begin
        if (div_stat.done) begin
          // push the freed index in front of the head
          ram_we     = free_ok;
          ram_waddr  = quot[IDX_W-1:0];
          ram_wdata  = free_head;
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // configuration, allocator state and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pool_base   <= '0;
      block_bytes <= BYTES_W'(1);
      block_count <= '0;
      free_head   <= LINK_END;
      blocks_used <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (cfg_reg_t'(cfg_index))
          REG_POOL_BASE:   pool_base   <= cfg_data;
          REG_BLOCK_BYTES: block_bytes <= cfg_data[BYTES_W-1:0];
          REG_BLOCK_COUNT: block_count <= cfg_data[COUNT_W-1:0];
          default: ;
        endcase
      end

      // drained result; the emit step reloads it in the same cycle itself
      if (out_valid && !out_stall && state != S_EMIT) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_accept) begin
            init_cnt   <= '0;
            init_last  <= IDX_W'(CMP_W'(block_count) - 1'b1);
            res_addr   <= '0;
            case (op_in)
              OP_INIT:  res_status <= count_bad ? ST_BAD_LEN : ST_OK;
              OP_ALLOC: res_status <= head_empty ? ST_EMPTY : ST_OK;
              OP_FREE:  res_status <= free_pre_bad ? ST_REJECT : ST_OK;
              default:  res_status <= ST_OK;
            endcase
          end
        end
        S_INIT: begin
          init_cnt <= init_cnt + 1'b1;
          if (init_cnt == init_last) begin
            free_head   <= '0;
            blocks_used <= '0;
          end
        end
        S_ALLOC_RD: begin
          // link of the popped block is in from the RAM now
          free_head <= link_in;
          prod      <= PROD_W'(free_head[IDX_W-1:0]) * PROD_W'(block_bytes);
          if (blocks_used != USED_MAX) begin
            blocks_used <= blocks_used + 1'b1;
          end
        end
        S_ALLOC_ADD: begin
          res_addr <= base_m + ADDR_WIDTH'(prod);
        end
        S_DIV: begin
          if (div_stat.done) begin
            if (free_ok) begin
              free_head <= LINK_W'(quot);
              if (blocks_used != '0) begin
                blocks_used <= blocks_used - 1'b1;
              end
            end else begin
              res_status <= ST_REJECT;
            end
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid     <= 1'b1;
            status        <= res_status;
            block_address <= res_addr;
            used_count    <= blocks_used;
          end
        end
        default: ;
      endcase
    end
  end

  // head is a real index or the end marker
  a_head_range: assert property (@(posedge clk) disable iff (rst)
    free_head <= LINK_END)
    else $error("free list head out of range");

  // links are only written by init walk or a free push
  a_ram_we_state: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == S_INIT || state == S_DIV))
    else $error("link RAM written outside init or free");

  // used count only moves in the last init step, the allocate read step or the free step
  a_used_moves: assert property (@(posedge clk) disable iff (rst)
    !$stable(blocks_used) |->
      ($past(state) == S_INIT || $past(state) == S_ALLOC_RD || $past(state) == S_DIV))
    else $error("used count changed outside an update step");

  // a result only appears from the emit step
  a_out_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_EMIT)
    else $error("result raised outside emit");

  // divider is never restarted while a free is pending
  a_div_start: assert property (@(posedge clk) disable iff (rst)
    div_start |-> state == S_IDLE)
    else $error("divider started outside idle");

endmodule

>>> rtl/core/fbpa_ram.sv
// ----------------------------------------------------------------------------
// fbpa_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module fbpa_ram #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/core/fbpa_div.sv
// ----------------------------------------------------------------------------
// fbpa_div
// Radix-2 restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module fbpa_div import fbpa_pkg::*; #(
  parameter int DW = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [DW-1:0]      dividend,
  input  logic [BYTES_W-1:0] divisor,
  output div_stat_t          stat,
  output logic [DW-1:0]      quotient
);

  localparam int CNT_W = $clog2(DW + 1);

  logic               busy;
  logic               done;
  logic [CNT_W-1:0]   cnt;
  logic [DW-1:0]      quo;
  logic [BYTES_W-1:0] rem;
  logic [BYTES_W-1:0] dsr;
  logic [BYTES_W:0]   trial;
  logic [BYTES_W:0]   diff;
  logic               fits;

  assign trial = {rem, quo[DW-1]};
  assign fits  = trial >= {1'b0, dsr};
  assign diff  = trial - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        quo  <= dividend;
        rem  <= '0;
        dsr  <= divisor;
      end else if (busy) begin
        rem <= fits ? diff[BYTES_W-1:0] : trial[BYTES_W-1:0];
        quo <= {quo[DW-2:0], fits};
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(DW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign stat.done     = done;
  assign stat.rem_zero = (rem == '0);
  assign quotient      = quo;

endmodule
